### rtl/core/skvs_pkg.sv
package skvs_pkg;

    localparam int KEY_BITS = 32;
    localparam int VAL_BITS = 64;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DRAINING = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                       cmd;
        logic signed [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0]        value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [KEY_BITS-1:0] out_key;
        logic [VAL_BITS-1:0]        out_value;
        logic                       last;
    } t_result;

    // one stored pair
    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0]        value;
    } t_entry;

    // merge sequencer status towards the command controller
    typedef struct packed {
        logic done;
        logic we;
        logic src;
    } t_merge_stat;

endpackage

### rtl/core/skvs_bank.sv
module skvs_bank
    import skvs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  t_entry        i_wd,
    input  logic [AW-1:0] i_ra,
    input  logic [AW-1:0] i_rb,
    output t_entry        o_ra,
    output t_entry        o_rb
);

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_ra <= r_mem[i_ra];
        o_rb <= r_mem[i_rb];
    end

endmodule

### rtl/core/skvs_merge.sv
module skvs_merge
    import skvs_pkg::*;
#(
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_count,
    input  t_entry        i_head_a,
    input  t_entry        i_head_b,
    output logic [AW-1:0] o_ra,
    output logic [AW-1:0] o_rb,
    output logic [AW-1:0] o_wa,
    output t_entry        o_wd,
    output t_merge_stat   o_stat
);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_RUN   = 2'd1;
    localparam logic [1:0] M_MERGE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_n, n_n, r_w, n_w, r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_src, n_src, r_done, n_done;
    logic [CW:0]   lo_w, lo_2w, w_2;
    logic [CW-1:0] run_mid, run_hi;
    logic          take_b;

    // run bounds clamped to the set size
    always_comb begin
        lo_w    = {1'b0, r_lo} + {1'b0, r_w};
        lo_2w   = lo_w + {1'b0, r_w};
        w_2     = {r_w, 1'b0};
        run_mid = (lo_w  > {1'b0, r_n}) ? r_n : lo_w[CW-1:0];
        run_hi  = (lo_2w > {1'b0, r_n}) ? r_n : lo_2w[CW-1:0];
        take_b  = (r_i >= r_mid) || ((r_j < r_hi) && (i_head_b.key < i_head_a.key));
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_src   = r_src;
        n_done  = 1'b0;
        o_ra    = r_i[AW-1:0];
        o_rb    = r_j[AW-1:0];
        o_wa    = r_k[AW-1:0];
        o_wd    = take_b ? i_head_b : i_head_a;
        o_stat  = '{done: r_done, we: 1'b0, src: r_src};
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_n   = i_count;
                    n_w   = CW'(1);
                    n_lo  = '0;
                    n_src = 1'b0;
                    if (i_count <= CW'(1)) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = M_RUN;
                    end
                end
            end
            M_RUN: begin
                n_i     = r_lo;
                n_j     = run_mid;
                n_k     = r_lo;
                n_mid   = run_mid;
                n_hi    = run_hi;
                o_ra    = r_lo[AW-1:0];
                o_rb    = run_mid[AW-1:0];
                n_state = M_MERGE;
            end
            M_MERGE: begin
                o_stat.we = 1'b1;
                if (take_b) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_i = r_i + CW'(1);
                end
                n_k  = r_k + CW'(1);
                o_ra = n_i[AW-1:0];
                o_rb = n_j[AW-1:0];
                if (n_k == r_hi) begin
                    if (r_hi == r_n) begin
                        // pass complete, the written bank becomes the source
                        n_src = ~r_src;
                        n_lo  = '0;
                        if (w_2 >= {1'b0, r_n}) begin
                            n_done  = 1'b1;
                            n_state = M_IDLE;
                        end else begin
                            n_w     = w_2[CW-1:0];
                            n_state = M_RUN;
                        end
                    end else begin
                        n_lo    = r_hi;
                        n_state = M_RUN;
                    end
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_src   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_done  <= n_done;
        end
        r_n   <= n_n;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
    end

endmodule

### rtl/core/stable_key_value_sorter.sv
// stable key/value sorter: a push keeps the block idle, its result strobes in the next cycle
// pop while draining: busy while in S_POP_OUT, result strobes in the cycle after it
// first pop of a set: bottom-up merge sort over two ping-pong banks, one element per
// cycle in the merge state (a setup state opens each run) through a shared compare unit
// synchronous active-low reset empties the store; results cannot be stalled
module stable_key_value_sorter
    import skvs_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    // controller states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SORT    = 2'd1;
    localparam logic [1:0] S_POP_RD  = 2'd2;
    localparam logic [1:0] S_POP_OUT = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;     // pairs held in the set
    logic [CW-1:0] r_rp, n_rp;           // next sorted position to pop
    logic          r_draining, n_draining;
    logic          r_strobe, n_strobe;
    t_result       r_result, n_result;

    logic          accept;
    logic          push_we;
    logic          m_start;

    // merge sequencer
    logic [AW-1:0] m_ra, m_rb, m_wa;
    t_entry        m_wd;
    t_merge_stat   m_stat;

    // bank ports: bank 0 receives pushes and is the first merge source
    logic [AW-1:0] bank_ra, bank_rb;
    logic          we0, we1;
    logic [AW-1:0] wa0;
    t_entry        wd0;
    t_entry        rd0_a, rd0_b, rd1_a, rd1_b;
    t_entry        src_a, src_b;

    assign accept = start & ~busy;
    assign busy   = (r_state != S_IDLE);

    // source bank selection follows the merge pass parity
    assign src_a = m_stat.src ? rd1_a : rd0_a;
    assign src_b = m_stat.src ? rd1_b : rd0_b;

    // address routing: merge owns both read ports while sorting; port a takes the pop address otherwise
    assign bank_ra = (r_state == S_SORT) ? m_ra : r_rp[AW-1:0];
    assign bank_rb = m_rb;
    assign we0     = push_we | (m_stat.we & m_stat.src);
    assign we1     = m_stat.we & ~m_stat.src;
    assign wa0     = push_we ? r_count[AW-1:0] : m_wa;
    assign wd0     = push_we ? t_entry'{key: i_cmd.key, value: i_cmd.value} : m_wd;

    skvs_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_bank0 (
        .i_clk (i_clk),
        .i_we  (we0),
        .i_wa  (wa0),
        .i_wd  (wd0),
        .i_ra  (bank_ra),
        .i_rb  (bank_rb),
        .o_ra  (rd0_a),
        .o_rb  (rd0_b)
    );

    skvs_bank #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_bank1 (
        .i_clk (i_clk),
        .i_we  (we1),
        .i_wa  (m_wa),
        .i_wd  (m_wd),
        .i_ra  (bank_ra),
        .i_rb  (bank_rb),
        .o_ra  (rd1_a),
        .o_rb  (rd1_b)
    );

    skvs_merge #(
        .CW (CW),
        .AW (AW)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (m_start),
        .i_count  (r_count),
        .i_head_a (src_a),
        .i_head_b (src_b),
        .o_ra     (m_ra),
        .o_rb     (m_rb),
        .o_wa     (m_wa),
        .o_wd     (m_wd),
        .o_stat   (m_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rp       = r_rp;
        n_draining = r_draining;
        n_strobe   = 1'b0;
        n_result   = '0;
        push_we    = 1'b0;
        m_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.cmd == CMD_PUSH) begin
                        n_strobe = 1'b1;
                        if (r_draining) begin
                            n_result.status = ST_DRAINING;
                        end else if (r_count >= CW'(MAX_ITEMS)) begin
                            n_result.status = ST_FULL;
                        end else begin
                            n_result.status = ST_OK;
                            push_we         = 1'b1;
                            n_count         = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_strobe        = 1'b1;
                        n_result.status = ST_EMPTY;
                    end else if (r_draining) begin
                        // read of the next position is issued in this cycle
                        n_state = S_POP_OUT;
                    end else begin
                        m_start = 1'b1;
                        n_rp    = '0;
                        n_state = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (m_stat.done) begin
                    n_draining = 1'b1;
                    n_state    = S_POP_RD;
                end
            end
            S_POP_RD: begin
                n_state = S_POP_OUT;
            end
            S_POP_OUT: begin
                n_strobe           = 1'b1;
                n_result.status    = ST_OK;
                n_result.out_key   = src_a.key;
                n_result.out_value = src_a.value;
                if ((r_rp + CW'(1)) >= r_count) begin
                    // final pair of the set: empty the store
                    n_result.last = 1'b1;
                    n_count       = '0;
                    n_rp          = '0;
                    n_draining    = 1'b0;
                end else begin
                    n_rp = r_rp + CW'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rp       <= '0;
            r_draining <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rp       <= n_rp;
            r_draining <= n_draining;
            r_strobe   <= n_strobe;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
